### hw/rtl/iovps_pkg.sv
// ----------------------------------------------------------------------------
// iovps_pkg
// Shared widths, constants and controller/datapath types for the I/O vector
// part splitter.
// ----------------------------------------------------------------------------
package iovps_pkg;

	localparam int OFFSET_W = 64;
	localparam int LEN_W    = 20;
	localparam int TAG_W    = 16;
	localparam int LIMIT_W  = 31;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET    = LIMIT_W'(1048576);
	localparam logic [LIMIT_W-1:0] LIMIT_FLOOR    = LIMIT_W'(65536);
	localparam logic [LIMIT_W-1:0] ROOM_THRESHOLD = LIMIT_W'(4096);

	localparam logic KIND_SEGMENT = 1'b0;
	localparam logic KIND_CLOSE   = 1'b1;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_FIT,
		OP_CLOSE,
		OP_SPLIT,
		OP_FINAL_CLOSE
	} op_t;

	typedef struct packed {
		logic take;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic desc_valid;
		logic fits;
		logic room_small;
		logic out_free;
		logic eol;
	} sts_t;

endpackage

### hw/rtl/iovps_if.sv
// ----------------------------------------------------------------------------
// iovps_if
// Valid/ready channels of the part splitter: descriptors, results and the
// byte limit write port.
// ----------------------------------------------------------------------------
interface iovps_desc_if;
	logic                           valid;
	logic                           ready;
	logic [iovps_pkg::OFFSET_W-1:0] base_offset;
	logic [iovps_pkg::LEN_W-1:0]    byte_length;
	logic                           creates_file;
	logic [iovps_pkg::TAG_W-1:0]    descriptor_tag;
	logic                           end_of_list;

	modport source (output valid, base_offset, byte_length, creates_file,
		descriptor_tag, end_of_list, input ready);
	modport sink (input valid, base_offset, byte_length, creates_file,
		descriptor_tag, end_of_list, output ready);
endinterface

interface iovps_result_if;
	logic                           valid;
	logic                           ready;
	logic                           result_kind;
	logic [iovps_pkg::OFFSET_W-1:0] segment_offset;
	logic [iovps_pkg::LIMIT_W-1:0]  segment_length;
	logic                           segment_creates;
	logic [iovps_pkg::TAG_W-1:0]    segment_tag;
	logic                           last_of_run;

	modport source (output valid, result_kind, segment_offset, segment_length,
		segment_creates, segment_tag, last_of_run, input ready);
	modport sink (input valid, result_kind, segment_offset, segment_length,
		segment_creates, segment_tag, last_of_run, output ready);
endinterface

interface iovps_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [iovps_pkg::LIMIT_W-1:0] part_byte_limit;

	modport source (output valid, part_byte_limit, input ready);
	modport sink (input valid, part_byte_limit, output ready);
endinterface

### hw/rtl/io_vector_part_splitter.sv
// ----------------------------------------------------------------------------
// io_vector_part_splitter
// Packs I/O descriptors into parts of at most max(part_byte_limit, 65536)
// bytes, cutting descriptors at part boundaries and reporting part closes.
//
//   channel  dir  beat
//   desc     in   one descriptor (offset, length, create, tag, end of list)
//   result   out  one segment or part close, last_of_run on the final one
//   cfg      in   part_byte_limit write
//
// A descriptor is taken while the sequencer is idle, then its results leave one
// per cycle from the output register while result.ready holds; the single
// sequencer walks the cut/close steps.
// Reset clears the part fill and restores the limit to 1048576.
// A stalled result port holds the sequencer; no new descriptor is taken
// until every result of the current one is in the output register.
// ----------------------------------------------------------------------------
module io_vector_part_splitter (
	input logic            clk,
	input logic            arst_n,
	iovps_desc_if.sink     desc,
	iovps_result_if.source result,
	iovps_cfg_if.sink      cfg
);
	import iovps_pkg::*;

	cmd_t cmd;
	sts_t sts;

	iovps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	iovps_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.desc   (desc),
		.result (result),
		.cfg    (cfg)
	);

endmodule

### hw/rtl/iovps_ctrl.sv
// ----------------------------------------------------------------------------
// iovps_ctrl
// Sequencer: takes one descriptor, then issues one result operation per free
// output slot until the descriptor is fully placed and, at end of list, closed.
// ----------------------------------------------------------------------------
module iovps_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  iovps_pkg::sts_t sts,
	output iovps_pkg::cmd_t cmd
);
	import iovps_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_CLOSE,
		ST_FINAL
	} state_t;

	state_t state_q;

	always_comb begin
		cmd.take = 1'b0;
		cmd.op   = OP_NONE;
		unique case (state_q)
			ST_IDLE: cmd.take = 1'b1;
			ST_RUN: begin
				if (sts.out_free) begin
					if (sts.fits) begin
						cmd.op = OP_FIT;
					end else if (sts.room_small) begin
						cmd.op = OP_CLOSE;
					end else begin
						cmd.op = OP_SPLIT;
					end
				end
			end
			ST_CLOSE: if (sts.out_free) cmd.op = OP_CLOSE;
			ST_FINAL: if (sts.out_free) cmd.op = OP_FINAL_CLOSE;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (sts.desc_valid) state_q <= ST_RUN;
				ST_RUN: begin
					if (sts.out_free) begin
						if (sts.fits) begin
							state_q <= sts.eol ? ST_FINAL : ST_IDLE;
						end else if (!sts.room_small) begin
							state_q <= ST_CLOSE;
						end
					end
				end
				ST_CLOSE: if (sts.out_free) state_q <= ST_RUN;
				ST_FINAL: if (sts.out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/iovps_dp.sv
// ----------------------------------------------------------------------------
// iovps_dp
// Datapath: descriptor registers, part fill, byte limit, room compare and
// the result output register.
// ----------------------------------------------------------------------------
module iovps_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  iovps_pkg::cmd_t cmd,
	output iovps_pkg::sts_t sts,
	iovps_desc_if.sink      desc,
	iovps_result_if.source  result,
	iovps_cfg_if.sink       cfg
);
	import iovps_pkg::*;

	logic [OFFSET_W-1:0] off_q;
	logic [LEN_W-1:0]    rem_q;
	logic                cr_q;
	logic [TAG_W-1:0]    tag_q;
	logic                eol_q;
	logic [LIMIT_W-1:0]  fill_q;
	logic [LIMIT_W-1:0]  limit_q;

	logic                out_valid_q;
	logic                kind_q;
	logic [OFFSET_W-1:0] seg_off_q;
	logic [LIMIT_W-1:0]  seg_len_q;
	logic                seg_cr_q;
	logic [TAG_W-1:0]    seg_tag_q;
	logic                last_q;

	logic [LIMIT_W-1:0] limit_eff;
	logic [LIMIT_W:0]   sum;
	logic [LIMIT_W-1:0] room;
	logic               fits;
	logic               desc_fire;

	assign limit_eff = (limit_q < LIMIT_FLOOR) ? LIMIT_FLOOR : limit_q;
	assign sum       = {1'b0, fill_q} + (LIMIT_W + 1)'(rem_q);
	assign fits      = sum <= {1'b0, limit_eff};
	assign room      = (fill_q >= limit_eff) ? '0 : limit_eff - fill_q;
	assign desc_fire = desc.valid && cmd.take;

	assign desc.ready = cmd.take;
	assign cfg.ready  = 1'b1;

	assign sts.desc_valid = desc.valid;
	assign sts.fits       = fits;
	assign sts.room_small = room <= ROOM_THRESHOLD;
	assign sts.out_free   = !out_valid_q || result.ready;
	assign sts.eol        = eol_q;

	assign result.valid           = out_valid_q;
	assign result.result_kind     = kind_q;
	assign result.segment_offset  = seg_off_q;
	assign result.segment_length  = seg_len_q;
	assign result.segment_creates = seg_cr_q;
	assign result.segment_tag     = seg_tag_q;
	assign result.last_of_run     = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			limit_q     <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				limit_q <= cfg.part_byte_limit;
			end
			unique case (cmd.op)
				OP_FIT: begin
					fill_q      <= sum[LIMIT_W-1:0];
					out_valid_q <= 1'b1;
				end
				OP_CLOSE, OP_SPLIT, OP_FINAL_CLOSE: begin
					fill_q      <= '0;
					out_valid_q <= 1'b1;
				end
				OP_NONE: if (result.ready) out_valid_q <= 1'b0;
				default: out_valid_q <= out_valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (desc_fire) begin
			off_q <= desc.base_offset;
			rem_q <= desc.byte_length;
			cr_q  <= desc.creates_file;
			tag_q <= desc.descriptor_tag;
			eol_q <= desc.end_of_list;
		end
		unique case (cmd.op)
			OP_FIT: begin
				kind_q    <= KIND_SEGMENT;
				seg_off_q <= off_q;
				seg_len_q <= LIMIT_W'(rem_q);
				seg_cr_q  <= cr_q;
				seg_tag_q <= tag_q;
				last_q    <= !eol_q;
			end
			OP_SPLIT: begin
				kind_q    <= KIND_SEGMENT;
				seg_off_q <= off_q;
				seg_len_q <= room;
				seg_cr_q  <= cr_q;
				seg_tag_q <= tag_q;
				last_q    <= 1'b0;
				off_q     <= off_q + OFFSET_W'(room[LEN_W-1:0]);
				rem_q     <= rem_q - room[LEN_W-1:0];
				cr_q      <= 1'b0;
			end
			OP_CLOSE, OP_FINAL_CLOSE: begin
				kind_q    <= KIND_CLOSE;
				seg_off_q <= '0;
				seg_len_q <= '0;
				seg_cr_q  <= 1'b0;
				seg_tag_q <= '0;
				last_q    <= (cmd.op == OP_FINAL_CLOSE);
			end
			default: kind_q <= kind_q;
		endcase
	end

endmodule
